// File: hw/rtl/vfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg - shared types and constants for voxel face culling
// Item codes, register indexes, face corner tables and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package vfc_pkg;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } vfc_op_t;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } vfc_reg_t;

    localparam logic [7:0] EMPTY_COLOR = 8'hff;
    localparam int         SIZE_CAP    = 32;
    localparam int         NUM_FACES   = 6;
    localparam logic [2:0] LAST_STEP   = 3'd6;

    // Corner sign mask: bit 0 +x, bit 1 +y, bit 2 +z.
    localparam logic [2:0] CORNER_SIGN [8] = '{
        3'b000, 3'b001, 3'b011, 3'b010,
        3'b100, 3'b101, 3'b111, 3'b110
    };

    // Corners of each face in emission order.
    localparam logic [2:0] FACE_CORNERS [6][4] = '{
        '{3'd0, 3'd4, 3'd7, 3'd3},
        '{3'd2, 3'd6, 3'd5, 3'd1},
        '{3'd0, 3'd1, 3'd5, 3'd4},
        '{3'd7, 3'd6, 3'd2, 3'd3},
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd4, 3'd5, 3'd6, 3'd7}
    };

    // Controller to datapath.
    typedef struct packed {
        logic       load;
        logic       wr_en;
        logic       rd_en;
        logic       capture;
        logic [2:0] step;
        logic       emit;
        logic [2:0] face;
        logic [1:0] corner;
        logic       last;
    } vfc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       is_query;
        logic       in_range;
        logic       center_empty;
        logic [5:0] vis;
    } vfc_stat_t;

endpackage

// File: hw/rtl/voxel_face_culling_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culling_core - hidden face culling over a voxel store
// Stores voxel colours and, on a query, emits the corners of every face of
// the voxel that borders an empty or out-of-volume neighbour.
// ----------------------------------------------------------------------------
// Usage:
//  - Item channel: a word is taken when start is high and busy is low.
//    cmd = write stores color_in at (pos_x, pos_y, pos_z); no result.
//    cmd = query emits four corner words per visible face, -x first.
//  - Result channel: each word sits on the result ports for one cycle with
//    result_valid high; last marks the final corner. No back-pressure.
//  - Config channel: cfg_valid/cfg_ready (ready always high), cfg_index
//    0..2 selects size_x/y/z; index 3 is ignored. Write only while idle.
//  - Sequence: a write is accepted, then stored in the decode step. A query
//    is accepted and decoded, then does seven reads of the single read port
//    (each a read then a capture: centre then six neighbours), a face scan
//    and four corner words per visible face; out-of-range or empty voxels
//    end after decode or the first read. The first corner appears in the
//    cycle after emission starts, set by the output register.
//  - Reset: sizes return to 32, control goes idle; the store itself is not
//    cleared, so an unwritten voxel reads as anything.
// ----------------------------------------------------------------------------
module voxel_face_culling_core #(
    parameter int DIM_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                start,
    output logic                busy,
    input  logic                cmd,
    input  logic [4:0]          pos_x,
    input  logic [4:0]          pos_y,
    input  logic [4:0]          pos_z,
    input  logic [7:0]          color_in,
    // configuration channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    // result channel
    output logic                result_valid,
    output logic [2:0]          face,
    output logic signed [6:0]   corner_x,
    output logic signed [6:0]   corner_y,
    output logic signed [6:0]   corner_z,
    output logic [7:0]          color_out,
    output logic                last
);

    vfc_pkg::vfc_cmd_t  ctl_cmd;
    vfc_pkg::vfc_stat_t dp_stat;

    // Config words are written straight into the size registers, so the port never stalls.
    assign cfg_ready = 1'b1;

    vfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .stat   (dp_stat),
        .cmd    (ctl_cmd)
    );

    vfc_datapath #(
        .DIM_MAX (DIM_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_in       (cmd),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .color_in     (color_in),
        .cmd          (ctl_cmd),
        .stat         (dp_stat),
        .result_valid (result_valid),
        .face         (face),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .corner_z     (corner_z),
        .color_out    (color_out),
        .last         (last)
    );

endmodule

// File: hw/rtl/vfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_ctrl - sequencing state machine
// Walks decode, seven store reads (centre then six neighbours), face scan
// and corner emission.
// ----------------------------------------------------------------------------
module vfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  vfc_pkg::vfc_stat_t  stat,
    output vfc_pkg::vfc_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CAPTURE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [2:0] step_reg;
    logic [2:0] face_reg;
    logic [1:0] corner_reg;
    logic       busy_reg;

    logic [3:0] first_vis;
    logic [3:0] next_vis;

    function automatic int vis_pkg_hi();
        return vfc_pkg::NUM_FACES - 1;
    endfunction

    // Lowest visible face at or above 'from'; bit 3 flags a hit.
    function automatic logic [3:0] find_vis(input logic [5:0] vis, input logic [2:0] from);
        logic [3:0] res;
        res = 4'd0;
        for (int i = vis_pkg_hi(); i >= 0; i--) begin
            if (vis[i] && (3'(i) >= from)) begin
                res = {1'b1, 3'(i)};
            end
        end
        return res;
    endfunction

    assign first_vis = find_vis(stat.vis, 3'd0);
    assign next_vis  = find_vis(stat.vis, 3'(face_reg + 3'd1));

    always_comb
    begin
        cmd         = '0;
        cmd.load    = (state_reg == ST_IDLE) && start;
        cmd.wr_en   = (state_reg == ST_DECODE) && !stat.is_query;
        cmd.rd_en   = (state_reg == ST_READ);
        cmd.capture = (state_reg == ST_CAPTURE);
        cmd.step    = step_reg;
        cmd.emit    = (state_reg == ST_EMIT);
        cmd.face    = face_reg;
        cmd.corner  = corner_reg;
        cmd.last    = (corner_reg == 2'd3) && !next_vis[3];
    end

    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= 3'd0;
            face_reg   <= 3'd0;
            corner_reg <= 2'd0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DECODE;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_DECODE:
                begin
                    if (stat.is_query && stat.in_range)
                    begin
                        step_reg  <= 3'd0;
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CAPTURE;
                end
                ST_CAPTURE:
                begin
                    if ((step_reg == 3'd0) && stat.center_empty)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    else if (step_reg == vfc_pkg::LAST_STEP)
                    begin
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= ST_READ;
                    end
                end
                ST_SCAN:
                begin
                    if (first_vis[3])
                    begin
                        face_reg   <= first_vis[2:0];
                        corner_reg <= 2'd0;
                        state_reg  <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                ST_EMIT:
                begin
                    if (corner_reg != 2'd3)
                    begin
                        corner_reg <= corner_reg + 2'd1;
                    end
                    else if (next_vis[3])
                    begin
                        face_reg   <= next_vis[2:0];
                        corner_reg <= 2'd0;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/vfc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_datapath - voxel store, size registers and corner arithmetic
// Holds the item, reads the store one address per read step and forms the
// registered result word.
// ----------------------------------------------------------------------------
module vfc_datapath #(
    parameter int DIM_MAX = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    // item
    input  logic                cmd_in,
    input  logic [4:0]          pos_x,
    input  logic [4:0]          pos_y,
    input  logic [4:0]          pos_z,
    input  logic [7:0]          color_in,
    // control
    input  vfc_pkg::vfc_cmd_t   cmd,
    output vfc_pkg::vfc_stat_t  stat,
    // result
    output logic                result_valid,
    output logic [2:0]          face,
    output logic signed [6:0]   corner_x,
    output logic signed [6:0]   corner_y,
    output logic signed [6:0]   corner_z,
    output logic [7:0]          color_out,
    output logic                last
);

    localparam int DIM_SQ = DIM_MAX * DIM_MAX;
    localparam int DEPTH  = DIM_SQ * DIM_MAX;
    localparam int AW     = $clog2(DEPTH);
    localparam int CAP    = (DIM_MAX < vfc_pkg::SIZE_CAP) ? DIM_MAX : vfc_pkg::SIZE_CAP;
    localparam logic [5:0] CAP_W = 6'(CAP);

    logic [7:0]     mem [DEPTH];

    logic [5:0]     size_x_reg, size_y_reg, size_z_reg;
    logic           op_reg;
    logic [4:0]     x_reg, y_reg, z_reg;
    logic [7:0]     cin_reg;
    logic [7:0]     rdata_reg;
    logic [7:0]     color_reg;
    logic [5:0]     vis_reg;

    logic           result_valid_reg;
    logic [2:0]     face_reg;
    logic [6:0]     cx_reg, cy_reg, cz_reg;
    logic           last_reg;

    logic [5:0]     eff_x, eff_y, eff_z;
    logic [5:0]     xw, yw, zw;
    logic [5:0]     nx, ny, nz;
    logic           n_inb;
    logic           in_store;
    logic [AW-1:0]  wr_addr, rd_addr;
    logic [2:0]     sign;
    logic [7:0]     cx_full, cy_full, cz_full;

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] x, input logic [5:0] y,
                                                input logic [5:0] z);
        return AW'(32'(z) * DIM_SQ + 32'(y) * DIM_MAX + 32'(x));
    endfunction

    assign eff_x = (size_x_reg > CAP_W) ? CAP_W : size_x_reg;
    assign eff_y = (size_y_reg > CAP_W) ? CAP_W : size_y_reg;
    assign eff_z = (size_z_reg > CAP_W) ? CAP_W : size_z_reg;

    assign xw = {1'b0, x_reg};
    assign yw = {1'b0, y_reg};
    assign zw = {1'b0, z_reg};

    // Neighbour coordinates for the current read step; step 0 is the centre.
    always_comb
    begin
        nx    = xw;
        ny    = yw;
        nz    = zw;
        n_inb = 1'b1;
        unique case (cmd.step)
            3'd1:
            begin
                nx    = xw - 6'd1;
                n_inb = (xw != 6'd0);
            end
            3'd2:
            begin
                nx    = xw + 6'd1;
                n_inb = (nx < eff_x);
            end
            3'd3:
            begin
                ny    = yw - 6'd1;
                n_inb = (yw != 6'd0);
            end
            3'd4:
            begin
                ny    = yw + 6'd1;
                n_inb = (ny < eff_y);
            end
            3'd5:
            begin
                nz    = zw - 6'd1;
                n_inb = (zw != 6'd0);
            end
            3'd6:
            begin
                nz    = zw + 6'd1;
                n_inb = (nz < eff_z);
            end
            default:
            begin
                n_inb = 1'b1;
            end
        endcase
    end

    assign rd_addr  = cell_addr(nx, ny, nz);
    assign wr_addr  = cell_addr(xw, yw, zw);
    assign in_store = (32'(x_reg) < DIM_MAX) && (32'(y_reg) < DIM_MAX)
                    && (32'(z_reg) < DIM_MAX);

    assign stat.is_query     = (op_reg == vfc_pkg::CMD_QUERY);
    assign stat.in_range     = (xw < eff_x) && (yw < eff_y) && (zw < eff_z);
    assign stat.center_empty = (rdata_reg == vfc_pkg::EMPTY_COLOR);
    assign stat.vis          = vis_reg;

    // Corner = 2*pos - (size-1) +/- 1, i.e. 2*pos - size + {0,2}.
    assign sign    = vfc_pkg::CORNER_SIGN[vfc_pkg::FACE_CORNERS[cmd.face][cmd.corner]];
    assign cx_full = {2'b00, x_reg, 1'b0} - {2'b00, eff_x} + {6'd0, sign[0], 1'b0};
    assign cy_full = {2'b00, y_reg, 1'b0} - {2'b00, eff_y} + {6'd0, sign[1], 1'b0};
    assign cz_full = {2'b00, z_reg, 1'b0} - {2'b00, eff_z} + {6'd0, sign[2], 1'b0};

    // Store port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && in_store)
        begin
            mem[wr_addr] <= cin_reg;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= cmd_in;
            x_reg   <= pos_x;
            y_reg   <= pos_y;
            z_reg   <= pos_z;
            cin_reg <= color_in;
            vis_reg <= 6'd0;
        end
        else if (cmd.capture)
        begin
            if (cmd.step == 3'd0)
            begin
                color_reg <= rdata_reg;
            end
            else
            begin
                vis_reg[3'(cmd.step - 3'd1)] <= !n_inb
                                             || (rdata_reg == vfc_pkg::EMPTY_COLOR);
            end
        end
        if (cmd.emit)
        begin
            face_reg <= cmd.face;
            cx_reg   <= cx_full[6:0];
            cy_reg   <= cy_full[6:0];
            cz_reg   <= cz_full[6:0];
            last_reg <= cmd.last;
        end
    end

    // Configuration and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg       <= 6'd32;
            size_y_reg       <= 6'd32;
            size_z_reg       <= 6'd32;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vfc_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                    vfc_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                    vfc_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign face         = face_reg;
    assign corner_x     = $signed(cx_reg);
    assign corner_y     = $signed(cy_reg);
    assign corner_z     = $signed(cz_reg);
    assign color_out    = color_reg;
    assign last         = last_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for voxel_face_culling_core
// Walks a short directed table of voxel writes, queries and size settings,
// then runs randomised phases under several volume sizes. Every corner word
// from the block is compared against an in-bench culling predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int          STORE_DIM     = 32;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASE_ITEMS   = 34;
    localparam int          NUM_PHASES    = 10;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;   // index with no register

    // Emission order of the corners of each face, -x first.
    localparam int FACE_ORDER [6][4] = '{
        '{0, 4, 7, 3}, '{2, 6, 5, 1}, '{0, 1, 5, 4},
        '{7, 6, 2, 3}, '{3, 2, 1, 0}, '{4, 5, 6, 7}
    };

    // Centre first, then the six neighbours.
    localparam int STEP_X [7] = '{0, -1, 1, 0, 0, 0, 0};
    localparam int STEP_Y [7] = '{0, 0, 0, -1, 1, 0, 0};
    localparam int STEP_Z [7] = '{0, 0, 0, 0, 0, -1, 1};

    // Sizes per random phase: extremes 0, 1, 32 and saturating values included.
    localparam logic [5:0] PHASE_SIZES [NUM_PHASES][3] = '{
        '{6'd4, 6'd4, 6'd4},  '{6'd2, 6'd3, 6'd2},  '{6'd1, 6'd1, 6'd1},
        '{6'd0, 6'd3, 6'd3},  '{6'd3, 6'd0, 6'd3},  '{6'd63, 6'd2, 6'd2},
        '{6'd3, 6'd40, 6'd1}, '{6'd5, 6'd2, 6'd33}, '{6'd6, 6'd5, 6'd4},
        '{6'd32, 6'd32, 6'd32}
    };

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    // One directed step. n_due < 0: corner words come from the predictor only.
    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        reg_idx;
        logic [5:0]        reg_val;
        vfc_pkg::vfc_op_t  op;
        logic [4:0]        x;
        logic [4:0]        y;
        logic [4:0]        z;
        logic [7:0]        color;
        logic signed [5:0] n_due;
    } plan_row_t;

    localparam logic signed [5:0] BY_MODEL = -6'sd1;
    localparam int PLAN_LEN = 33;

    localparam plan_row_t DIRECTED [PLAN_LEN] = '{
        // lone voxel at the low corner, colour 0, every face open
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd1, 5'd0, 5'd0, 8'd255, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd0, 5'd1, 5'd0, 8'd255, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd1, 8'd255, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd0, 5'd0, 5'd0, 8'd255, 6'sd24},
        // high corner, colour 254, two faces hidden
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd31, 5'd31, 5'd31, 8'd254, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd30, 5'd31, 5'd31, 8'd7, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd31, 5'd30, 5'd31, 8'd255, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd31, 5'd31, 5'd30, 8'd7, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd31, 5'd31, 5'd31, 8'd0, BY_MODEL},
        // query of an empty voxel
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd31, 5'd30, 5'd31, 8'd0, 6'sd0},
        // fully enclosed voxel, then open its +z side
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd4, 5'd5, 5'd5, 8'd1, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd6, 5'd5, 5'd5, 8'd2, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd5, 5'd4, 5'd5, 8'd3, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd5, 5'd6, 5'd5, 8'd4, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd5, 5'd5, 5'd4, 8'd5, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd5, 5'd5, 5'd6, 8'd6, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd5, 5'd5, 5'd5, 8'd200, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd5, 5'd5, 5'd5, 8'd0, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd5, 5'd5, 5'd6, 8'd255, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd5, 5'd5, 5'd5, 8'd0, BY_MODEL},
        // unused register index must change nothing
        '{ROW_CFG, REG_UNUSED, 6'd63, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        // 1x1x1 volume: only the origin is inside
        '{ROW_CFG, vfc_pkg::REG_SIZE_X, 6'd1, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        '{ROW_CFG, vfc_pkg::REG_SIZE_Y, 6'd1, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        '{ROW_CFG, vfc_pkg::REG_SIZE_Z, 6'd1, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd24},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd1, 5'd0, 5'd0, 8'd0, 6'sd0},
        // zero size along x: nothing is inside
        '{ROW_CFG, vfc_pkg::REG_SIZE_X, 6'd0, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        // oversize x saturates to 32; neighbour at +x is empty, then filled
        '{ROW_CFG, vfc_pkg::REG_SIZE_X, 6'd63, vfc_pkg::CMD_WRITE, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd24},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_WRITE, 5'd1, 5'd0, 5'd0, 8'd9, 6'sd0},
        '{ROW_ITEM, REG_UNUSED, 6'd0, vfc_pkg::CMD_QUERY, 5'd0, 5'd0, 5'd0, 8'd0, 6'sd20}
    };

    typedef struct packed {
        logic [2:0]        face;
        logic signed [6:0] cx;
        logic signed [6:0] cy;
        logic signed [6:0] cz;
        logic [7:0]        color;
        logic              last;
    } corner_word_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              cmd = vfc_pkg::CMD_WRITE;
    logic [4:0]        pos_x = '0;
    logic [4:0]        pos_y = '0;
    logic [4:0]        pos_z = '0;
    logic [7:0]        color_in = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [5:0]        cfg_data = '0;
    logic              result_valid;
    logic [2:0]        face;
    logic signed [6:0] corner_x;
    logic signed [6:0] corner_y;
    logic signed [6:0] corner_z;
    logic [7:0]        color_out;
    logic              last;

    // ------------------------------------------------------------------------
    // Predictor state: mirror of the voxel store, which cells were written,
    // and the size registers as last written
    // ------------------------------------------------------------------------
    logic [7:0]   vox_mem [STORE_DIM*STORE_DIM*STORE_DIM];
    bit           stored  [STORE_DIM*STORE_DIM*STORE_DIM];
    logic [5:0]   dim_reg [3] = '{6'd32, 6'd32, 6'd32};
    corner_word_t corners_due [$];

    int          fail_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int unsigned cycle_cnt  = 0;
    corner_word_t want_word;

    voxel_face_culling_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .color_in     (color_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .face         (face),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .corner_z     (corner_z),
        .color_out    (color_out),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Culling predictor
    // ------------------------------------------------------------------------
    function automatic int cell_of(int x, int y, int z);
        return (z * STORE_DIM + y) * STORE_DIM + x;
    endfunction

    // Size in use: saturates at the store dimension.
    function automatic int eff_dim(int axis);
        int d;
        d = int'(dim_reg[axis]);
        if (d > vfc_pkg::SIZE_CAP) d = vfc_pkg::SIZE_CAP;
        if (d > STORE_DIM) d = STORE_DIM;
        return d;
    endfunction

    function automatic bit inside_box(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 &&
               x < eff_dim(0) && y < eff_dim(1) && z < eff_dim(2);
    endfunction

    // A face is drawn when its neighbour is empty or outside the volume.
    function automatic bit side_open(int x, int y, int z);
        if (!inside_box(x, y, z))
            return 1'b1;
        return vox_mem[cell_of(x, y, z)] == vfc_pkg::EMPTY_COLOR;
    endfunction

    function automatic int half_step(bit up);
        return up ? 1 : -1;
    endfunction

    // Queues the corner words a query produces; n returns how many.
    task automatic cull_faces(input int x, input int y, input int z, output int n);
        int           f;
        int           k;
        int           top;
        int           cx;
        int           cy;
        int           cz;
        logic [2:0]   id;
        logic [7:0]   col;
        bit   [5:0]   bare;
        corner_word_t w;
        n = 0;
        if (!inside_box(x, y, z))
            return;
        col = vox_mem[cell_of(x, y, z)];
        if (col == vfc_pkg::EMPTY_COLOR)
            return;
        bare[0] = side_open(x - 1, y, z);
        bare[1] = side_open(x + 1, y, z);
        bare[2] = side_open(x, y - 1, z);
        bare[3] = side_open(x, y + 1, z);
        bare[4] = side_open(x, y, z - 1);
        bare[5] = side_open(x, y, z + 1);
        if (bare == '0)
            return;
        top = 5;
        while (!bare[top])
            top--;
        // centre in half-voxel units, volume centred on the origin
        cx = 2 * x - (eff_dim(0) - 1);
        cy = 2 * y - (eff_dim(1) - 1);
        cz = 2 * z - (eff_dim(2) - 1);
        for (f = 0; f < 6; f++)
        begin
            if (bare[f])
            begin
                for (k = 0; k < 4; k++)
                begin
                    id      = 3'(FACE_ORDER[f][k]);
                    w.face  = 3'(f);
                    w.cx    = 7'(cx + half_step(id[0] ^ id[1]));
                    w.cy    = 7'(cy + half_step(id[1]));
                    w.cz    = 7'(cz + half_step(id[2]));
                    w.color = col;
                    w.last  = (f == top) && (k == 3);
                    corners_due.push_back(w);
                    n++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers; each is entered and left in a rising-edge time step
    // ------------------------------------------------------------------------

    // Presents one item word, waits for it to be taken, then updates the
    // predictor. The sender runs in bursts: at the end of a burst start is
    // dropped for a random gap, and some bursts are long with no gap at all.
    task automatic send_item(input vfc_pkg::vfc_op_t op, input int x, input int y,
                             input int z, input logic [7:0] c, output int n);
        int gap;
        start    <= 1'b1;
        cmd      <= op;
        pos_x    <= 5'(x);
        pos_y    <= 5'(y);
        pos_z    <= 5'(z);
        color_in <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n = 0;
        if (op == vfc_pkg::CMD_WRITE)
        begin
            vox_mem[cell_of(x, y, z)] = c;
            stored[cell_of(x, y, z)]  = 1'b1;
        end
        else
            cull_faces(x, y, z, n);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 7);
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The store is undefined until written, so every cell a query may read
    // (centre plus in-volume neighbours) gets a write first.
    task automatic prime_block(input int x, input int y, input int z);
        int         j;
        int         nx;
        int         ny;
        int         nz;
        int         n;
        logic [7:0] c;
        if (!inside_box(x, y, z))
            return;
        for (j = 0; j < 7; j++)
        begin
            nx = x + STEP_X[j];
            ny = y + STEP_Y[j];
            nz = z + STEP_Z[j];
            if (inside_box(nx, ny, nz) && !stored[cell_of(nx, ny, nz)])
            begin
                c = ($urandom_range(0, 1) == 0) ? vfc_pkg::EMPTY_COLOR
                                                : 8'($urandom_range(0, 254));
                send_item(vfc_pkg::CMD_WRITE, nx, ny, nz, c, n);
            end
        end
    endtask

    // Idle point: item channel quiet, every corner word in, block drained.
    task automatic settle();
        start <= 1'b0;
        while (corners_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx != REG_UNUSED)
            dim_reg[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_coord(int axis, bit anywhere);
        if (anywhere || eff_dim(axis) == 0)
            return $urandom_range(0, STORE_DIM - 1);
        return $urandom_range(0, eff_dim(axis) - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: one corner word per cycle, no back-pressure
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (corners_due.size() == 0)
            begin
                $error("corner word with none expected: face %0d (%0d,%0d,%0d)",
                       face, corner_x, corner_y, corner_z);
                fail_count++;
            end
            else
            begin
                want_word = corners_due.pop_front();
                check_field("face", want_word.face, face);
                check_field("corner_x", want_word.cx, corner_x);
                check_field("corner_y", want_word.cy, corner_y);
                check_field("corner_z", want_word.cz, corner_z);
                check_field("color_out", want_word.color, color_out);
                check_field("last", want_word.last, last);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int        i;
        int        p;
        int        n;
        int        roll;
        int        base;
        int        qx;
        int        qy;
        int        qz;
        bit        wide;
        plan_row_t row;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed counts are checked against what the
        // predictor queued; the words themselves are checked by the monitor.
        for (i = 0; i < PLAN_LEN; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                send_item(row.op, row.x, row.y, row.z, row.color, n);
                if (row.n_due >= 0 && n != row.n_due)
                begin
                    $error("directed row %0d: expected %0d corner words, predicted %0d",
                           i, row.n_due, n);
                    fail_count++;
                end
            end
        end

        // Random phases, one volume size each. Mostly in-volume writes and
        // queries; some words land anywhere in the store to hit the
        // out-of-range paths and every coordinate bit.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_reg(vfc_pkg::REG_SIZE_X, PHASE_SIZES[p][0]);
            write_reg(vfc_pkg::REG_SIZE_Y, PHASE_SIZES[p][1]);
            write_reg(vfc_pkg::REG_SIZE_Z, PHASE_SIZES[p][2]);
            base = items_sent;
            while (items_sent - base < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                begin
                    wide = roll < 10;
                    qx = pick_coord(0, wide);
                    qy = pick_coord(1, wide);
                    qz = pick_coord(2, wide);
                    send_item(vfc_pkg::CMD_WRITE, qx, qy, qz,
                              ($urandom_range(0, 99) < 35)
                                  ? vfc_pkg::EMPTY_COLOR
                                  : 8'($urandom_range(0, 255)),
                              n);
                end
                else
                begin
                    wide = $urandom_range(0, 99) < 15;
                    qx = pick_coord(0, wide);
                    qy = pick_coord(1, wide);
                    qz = pick_coord(2, wide);
                    prime_block(qx, qy, qz);
                    send_item(vfc_pkg::CMD_QUERY, qx, qy, qz,
                              8'($urandom_range(0, 255)), n);
                end
            end
        end

        // Drain; the watchdog bounds the wait for missing words.
        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_ctrl.sv
hw/rtl/vfc_datapath.sv
hw/rtl/voxel_face_culling_core.sv
test/tb.sv
